FILE: rtl/core/task_ready_queue_macros.svh
// ---------------------------------------------------------------------------
// Task ready queue assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TASK_READY_QUEUE_MACROS_SVH
`define TASK_READY_QUEUE_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define TRQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define TRQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define TRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/trq_pkg.sv
// ---------------------------------------------------------------------------
// Task ready queue package
// Item types, operation and status codes, and controller command bundle.
// ---------------------------------------------------------------------------
`default_nettype none

package trq_pkg;

  localparam int TASK_W     = 5;
  localparam int FUNC_W     = 2;
  localparam int REQ_PRIO_W = 8;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 6;
  localparam int NUM_IDS    = 2 ** TASK_W;

  // Operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INS_TAIL = 2'd0,
    FUNC_INS_PRIO = 2'd1,
    FUNC_REM_HEAD = 2'd2,
    FUNC_REM_TASK = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_ABSENT  = 2'd2,
    STAT_REFUSED = 2'd3
  } status_t;

  typedef struct packed {
    func_t                 func;
    logic [TASK_W-1:0]     task_id;
    logic [REQ_PRIO_W-1:0] priority_req;
  } in_item_t;

  typedef struct packed {
    status_t            status;
    logic               removed_valid;
    logic [TASK_W-1:0]  removed_task;
    logic               head_valid;
    logic [TASK_W-1:0]  head_task;
    logic [COUNT_W-1:0] task_count;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;
    logic eval;
    logic apply;
  } trq_cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/task_ready_queue.sv
// ---------------------------------------------------------------------------
// Task ready queue
// Ordered list of task numbers with tail insert, priority insert, head pop
// and named removal; every result reports head and count.
// ---------------------------------------------------------------------------
// Each operation has an evaluate step and an apply step: in the evaluate
// step, every slot of the cell row compares its priority and task number
// against the request in parallel and the per-slot flags and status are
// registered; in the apply step, the row shifts open or closed in one step,
// the count and membership map update and the result is loaded into the
// output register. A new item is accepted in the apply step as long as the
// output register is free, so the next item can enter while the last one
// finishes. The receiver can take a result during the evaluate step of the
// next item without holding it up; if the previous result is still held
// under stall when the next item reaches its apply step, that item waits
// there until the stall ends. Reset empties the list at once, no clearing pass is needed.
// A request priority keeps its low PRIO_BITS bits; an insert into a full
// list or of a task already listed is refused with status 3.
// ---------------------------------------------------------------------------
`default_nettype none

module task_ready_queue import trq_pkg::*; #(
  parameter int MAX_TASKS = 32,
  parameter int PRIO_BITS = 8
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_item,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_item
);

  trq_cmd_t cmd;

  // Sequencing and handshakes
  trq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Slot row and result register
  trq_datapath #(
    .MAX_TASKS (MAX_TASKS),
    .PRIO_BITS (PRIO_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_item (in_item),
    .result  (out_item)
  );

endmodule

`default_nettype wire

FILE: rtl/core/trq_datapath.sv
// ---------------------------------------------------------------------------
// Task ready queue datapath
// Row of slot cells with per-cell compare flags, shift network, count and
// membership map, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "task_ready_queue_macros.svh"

module trq_datapath import trq_pkg::*; #(
  parameter int MAX_TASKS = 32,
  parameter int PRIO_BITS = 8
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire trq_cmd_t  cmd,
  input  wire in_item_t  in_item,
  output out_item_t      result
);

  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  localparam int STAGES = $clog2(MAX_TASKS);

  // Slot row, slot 0 is the head
  logic [TASK_W-1:0]    slot_task_r   [MAX_TASKS];
  logic [TASK_W-1:0]    slot_task_nxt [MAX_TASKS];
  logic [PRIO_BITS-1:0] slot_prio_r   [MAX_TASKS];
  logic [PRIO_BITS-1:0] slot_prio_nxt [MAX_TASKS];

  logic [CNT_W-1:0]   occ_r, occ_nxt;
  logic [NUM_IDS-1:0] map_r, map_nxt;

  // Captured request
  func_t                func_r;
  logic [TASK_W-1:0]    task_r;
  logic [PRIO_BITS-1:0] prio_r;
  logic [PRIO_BITS+REQ_PRIO_W-1:0] prio_ext;

  // Evaluation results
  logic [MAX_TASKS-1:0] cell_valid, cell_le, cell_hit;
  logic [MAX_TASKS-1:0] flag_r, flag_nxt;
  logic                 head_gt_r, head_gt_nxt;
  status_t              status_r, status_nxt;
  logic                 listed, full, empty;

  // Shift masks
  logic [MAX_TASKS-1:0] suf [STAGES+1];
  logic [MAX_TASKS-1:0] pre [STAGES+1];
  logic [MAX_TASKS-1:0] ins_mask, rem_mask;
  logic                 change, is_insert;
  logic [TASK_W-1:0]    rem_task;

  out_item_t result_r, result_nxt;

  // Keep the low PRIO_BITS of the request priority
  assign prio_ext = {{PRIO_BITS{1'b0}}, in_item.priority_req};

  // Compare every slot against the request and pick the status
  always_comb begin
    listed = map_r[task_r];
    full   = occ_r >= CNT_W'(MAX_TASKS);
    empty  = occ_r == '0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      cell_valid[i] = CNT_W'(i) < occ_r;
      cell_le[i]    = cell_valid[i] && (slot_prio_r[i] <= prio_r);
      cell_hit[i]   = cell_valid[i] && (slot_task_r[i] == task_r);
    end
    flag_nxt    = '0;
    head_gt_nxt = 1'b0;
    status_nxt  = STAT_OK;
    case (func_r)
      FUNC_INS_TAIL: begin
        flag_nxt   = cell_valid;
        status_nxt = (listed || full) ? STAT_REFUSED : STAT_OK;
      end
      FUNC_INS_PRIO: begin
        flag_nxt    = cell_le;
        head_gt_nxt = !empty && (slot_prio_r[0] > prio_r);
        status_nxt  = (listed || full) ? STAT_REFUSED : STAT_OK;
      end
      FUNC_REM_HEAD: begin
        flag_nxt   = MAX_TASKS'(1);
        status_nxt = empty ? STAT_EMPTY : STAT_OK;
      end
      FUNC_REM_TASK: begin
        flag_nxt   = cell_hit;
        status_nxt = listed ? STAT_OK : STAT_ABSENT;
      end
      default: begin
        flag_nxt   = '0;
        status_nxt = STAT_ABSENT;
      end
    endcase
  end

  // Spread the flags: suffix OR for inserts, prefix OR for removes
  always_comb begin
    suf[0] = flag_r;
    pre[0] = flag_r;
    for (int k = 0; k < STAGES; k++) begin
      suf[k+1] = suf[k] | (suf[k] >> (1 << k));
      pre[k+1] = pre[k] | (pre[k] << (1 << k));
    end
    ins_mask = head_gt_r ? '1 : ~suf[STAGES];
    rem_mask = pre[STAGES];
  end

  assign change    = (cmd.apply && (status_r == STAT_OK));
  assign is_insert = (func_r == FUNC_INS_TAIL) || (func_r == FUNC_INS_PRIO);
  assign rem_task  = (func_r == FUNC_REM_HEAD) ? slot_task_r[0] : task_r;

  // Shift the slot row and update count and map
  always_comb begin
    slot_task_nxt = slot_task_r;
    slot_prio_nxt = slot_prio_r;
    occ_nxt       = occ_r;
    map_nxt       = map_r;
    if (change) begin
      if (is_insert) begin
        if (ins_mask[0]) begin
          slot_task_nxt[0] = task_r;
          slot_prio_nxt[0] = prio_r;
        end
        for (int i = 1; i < MAX_TASKS; i++) begin
          if (ins_mask[i] && ins_mask[i-1]) begin
            slot_task_nxt[i] = slot_task_r[i-1];
            slot_prio_nxt[i] = slot_prio_r[i-1];
          end else if (ins_mask[i]) begin
            slot_task_nxt[i] = task_r;
            slot_prio_nxt[i] = prio_r;
          end
        end
        occ_nxt         = occ_r + CNT_W'(1);
        map_nxt[task_r] = 1'b1;
      end else begin
        for (int i = 0; i < MAX_TASKS - 1; i++) begin
          if (rem_mask[i]) begin
            slot_task_nxt[i] = slot_task_r[i+1];
            slot_prio_nxt[i] = slot_prio_r[i+1];
          end
        end
        occ_nxt           = occ_r - CNT_W'(1);
        map_nxt[rem_task] = 1'b0;
      end
    end
  end

  // Build the result from the updated list
  always_comb begin
    result_nxt.status        = status_r;
    result_nxt.removed_valid = (status_r == STAT_OK) && !is_insert;
    result_nxt.removed_task  = result_nxt.removed_valid ? rem_task : '0;
    result_nxt.head_valid    = occ_nxt != '0;
    result_nxt.head_task     = result_nxt.head_valid ? slot_task_nxt[0] : '0;
    result_nxt.task_count    = COUNT_W'(occ_nxt);
  end

  // Control state: count and membership
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      map_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      map_r <= map_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r <= in_item.func;
      task_r <= in_item.task_id;
      prio_r <= prio_ext[PRIO_BITS-1:0];
    end
    if (cmd.eval) begin
      flag_r    <= flag_nxt;
      head_gt_r <= head_gt_nxt;
      status_r  <= status_nxt;
    end
    if (cmd.apply) begin
      result_r <= result_nxt;
    end
    slot_task_r <= slot_task_nxt;
    slot_prio_r <= slot_prio_nxt;
  end

  assign result = result_r;

  `TRQ_ASSERT_ALWAYS(a_map_matches_count, $countones(map_r) == occ_r,
    "membership map disagrees with task count")
  `TRQ_ASSERT_ALWAYS(a_count_bounded, occ_r <= CNT_W'(MAX_TASKS),
    "task count exceeds slot row")
  `TRQ_ASSERT_SAME(a_insert_has_room, change && is_insert, occ_r < CNT_W'(MAX_TASKS),
    "insert applied to a full list")

endmodule

`default_nettype wire

FILE: rtl/core/trq_ctrl.sv
// ---------------------------------------------------------------------------
// Task ready queue controller
// Sequences capture, evaluate and apply steps and owns both handshakes.
// ---------------------------------------------------------------------------
`default_nettype none
`include "task_ready_queue_macros.svh"

module trq_ctrl import trq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output trq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EVAL  = 3'b010,
    S_APPLY = 3'b100
  } ctl_state_t;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free, accept;

  // Take a new item when idle, or while finishing one with room at the output
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !((state_r == S_IDLE) || ((state_r == S_APPLY) && out_free));
  assign accept   = in_valid && !in_stall;

  // Advance the sequence
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EVAL;
      end
      S_EVAL: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (out_free) state_nxt = accept ? S_EVAL : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd.capture = accept;
    cmd.eval    = (state_r == S_EVAL);
    cmd.apply   = (state_r == S_APPLY) && out_free;
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.apply) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TRQ_ASSERT_NEXT(a_eval_then_apply, state_r == S_EVAL, state_r == S_APPLY,
    "evaluate step not followed by apply step")
  `TRQ_ASSERT_SAME(a_result_from_apply, $rose(out_valid_r), $past(state_r == S_APPLY),
    "result raised outside apply step")
  `TRQ_ASSERT_NEXT(a_accept_starts_eval, accept, state_r == S_EVAL,
    "accepted item did not start evaluation")

endmodule

`default_nettype wire

FILE: dv/task_ready_queue_tb.sv
// ---------------------------------------------------------------------------
// Task ready queue testbench
// Drives tail inserts, priority inserts, head pops and named removals through
// the valid/stall channels, predicts every result from a local copy of the
// ordered list and checks each returned item field by field. A short table of
// directed items comes first, then repeated fill and drain sequences run with
// random content under several sender and receiver idling patterns.
// ---------------------------------------------------------------------------
`default_nettype none

module task_ready_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import trq_pkg::*;

  localparam int MAX_TASKS    = 32;
  localparam int PRIO_BITS    = 8;
  localparam int RANDOM_ITEMS = 1700;
  localparam int PHASE_LEN    = 150;
  localparam int DRAIN_CYCLES = 10;
  localparam int N_DIRECTED   = 24;
  localparam int TIMEOUT_NS   = 2_000_000;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t res;
  } dir_row_t;

  localparam out_item_t FROM_MODEL = '0;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // Predicted list contents
  logic [TASK_W-1:0]    q_task [MAX_TASKS];
  logic [PRIO_BITS-1:0] q_prio [MAX_TASKS];
  int                   q_len = 0;
  logic [NUM_IDS-1:0]   q_members = '0;

  out_item_t expected_q [$];
  out_item_t want;
  dir_row_t  dir_table [N_DIRECTED];

  int  errors = 0;
  int  n_items = 0;
  int  n_results = 0;
  int  n_full_refused = 0;
  int  n_fills = 0;
  int  tx_pct = 0;
  int  rx_pct = 0;
  bit  filling = 1'b1;

  task_ready_queue #(
    .MAX_TASKS(MAX_TASKS),
    .PRIO_BITS(PRIO_BITS)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  // Clock
  initial begin
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
    $display("TEST FAILED");
    $finish;
  end

  // Take the task at a slot out of the list and close the gap
  function automatic logic [TASK_W-1:0] take_out(int pos);
    logic [TASK_W-1:0] t;
    t = q_task[pos];
    for (int i = pos; i + 1 < q_len; i++) begin
      q_task[i] = q_task[i + 1];
      q_prio[i] = q_prio[i + 1];
    end
    q_len--;
    q_members[t] = 1'b0;
    return t;
  endfunction

  // Apply one operation to the predicted list and return its result
  function automatic out_item_t apply_op(in_item_t it);
    out_item_t            r;
    logic [PRIO_BITS-1:0] p;
    int                   pos;
    r = '0;
    r.status = STAT_OK;
    p = it.priority_req[PRIO_BITS-1:0];
    case (it.func)
      FUNC_INS_TAIL, FUNC_INS_PRIO: begin
        if (q_members[it.task_id] || q_len >= MAX_TASKS) begin
          r.status = STAT_REFUSED;
        end else begin
          if (it.func == FUNC_INS_TAIL || q_len == 0) begin
            pos = q_len;
          end else if (q_prio[0] > p) begin
            pos = 0;
          end else begin
            // place after the last entry, seen from the tail, not above p
            pos = 1;
            for (int i = q_len; i > 0; i--) begin
              if (q_prio[i - 1] <= p) begin
                pos = i;
                break;
              end
            end
          end
          for (int i = q_len; i > pos; i--) begin
            q_task[i] = q_task[i - 1];
            q_prio[i] = q_prio[i - 1];
          end
          q_task[pos] = it.task_id;
          q_prio[pos] = p;
          q_len++;
          q_members[it.task_id] = 1'b1;
        end
      end
      FUNC_REM_HEAD: begin
        if (q_len == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          r.removed_valid = 1'b1;
          r.removed_task  = take_out(0);
        end
      end
      default: begin
        r.status = STAT_ABSENT;
        for (int i = 0; i < q_len; i++) begin
          if (q_task[i] == it.task_id) begin
            r.status        = STAT_OK;
            r.removed_valid = 1'b1;
            r.removed_task  = take_out(i);
            break;
          end
        end
      end
    endcase
    r.head_valid = (q_len != 0);
    r.head_task  = (q_len != 0) ? q_task[0] : '0;
    r.task_count = COUNT_W'(q_len);
    return r;
  endfunction

  // Build one random item, mostly steering the list toward full or empty
  function automatic in_item_t pick_item();
    in_item_t it;
    int       idx;
    bit       ins;
    it.func         = func_t'($urandom_range(0, 3));
    it.task_id      = TASK_W'($urandom_range(0, NUM_IDS - 1));
    it.priority_req = REQ_PRIO_W'($urandom_range(0, 255));
    if ($urandom_range(0, 99) >= 8) begin
      ins = filling ? ($urandom_range(0, 99) < 80) : ($urandom_range(0, 99) < 20);
      if (ins) begin
        it.func = ($urandom_range(0, 99) < 35) ? FUNC_INS_TAIL : FUNC_INS_PRIO;
        if (q_len < MAX_TASKS && $urandom_range(0, 99) < 85) begin
          idx = $urandom_range(0, NUM_IDS - 1);
          while (q_members[idx]) idx = (idx + 1) % NUM_IDS;
          it.task_id = TASK_W'(idx);
        end
        // narrow priorities give many ties
        case ($urandom_range(0, 3))
          0:       it.priority_req = REQ_PRIO_W'($urandom_range(0, 3));
          1:       it.priority_req = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default: it.priority_req = REQ_PRIO_W'($urandom_range(0, 255));
        endcase
      end else begin
        it.func = ($urandom_range(0, 99) < 40) ? FUNC_REM_HEAD : FUNC_REM_TASK;
        if (q_len > 0 && $urandom_range(0, 99) < 85)
          it.task_id = q_task[$urandom_range(0, q_len - 1)];
      end
    end
    return it;
  endfunction

  // Offer one item, hold it until accepted, then record its expectation
  task automatic send(in_item_t it, logic typed, out_item_t res);
    out_item_t model_res;
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if ((it.func == FUNC_INS_TAIL || it.func == FUNC_INS_PRIO) && q_len == MAX_TASKS)
      n_full_refused++;
    model_res = apply_op(it);
    expected_q.push_back(typed ? res : model_res);
    n_items++;
    @(negedge clk);
  endtask

  // Hold the sender until every expected result has come back
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic check_field(string name, int e, int a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
      errors++;
    end
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < rx_pct);
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, got %p", $time, out_item);
        errors++;
      end else begin
        want = expected_q.pop_front();
        check_field("status", want.status, out_item.status);
        check_field("removed_valid", want.removed_valid, out_item.removed_valid);
        check_field("removed_task", want.removed_task, out_item.removed_task);
        check_field("head_valid", want.head_valid, out_item.head_valid);
        check_field("head_task", want.head_task, out_item.head_task);
        check_field("task_count", want.task_count, out_item.task_count);
        n_results++;
      end
    end
  end

  // Main sequence
  initial begin
    int mode;
    dir_table = '{
      '{'{FUNC_REM_HEAD, 5'd0, 8'd0}, 1'b1,
        '{STAT_EMPTY, 1'b0, 5'd0, 1'b0, 5'd0, 6'd0}},
      '{'{FUNC_REM_TASK, 5'd31, 8'd255}, 1'b1,
        '{STAT_ABSENT, 1'b0, 5'd0, 1'b0, 5'd0, 6'd0}},
      '{'{FUNC_INS_PRIO, 5'd5, 8'd100}, 1'b1,
        '{STAT_OK, 1'b0, 5'd0, 1'b1, 5'd5, 6'd1}},
      '{'{FUNC_INS_TAIL, 5'd0, 8'd255}, 1'b1,
        '{STAT_OK, 1'b0, 5'd0, 1'b1, 5'd5, 6'd2}},
      '{'{FUNC_INS_TAIL, 5'd5, 8'd0}, 1'b1,
        '{STAT_REFUSED, 1'b0, 5'd0, 1'b1, 5'd5, 6'd2}},
      '{'{FUNC_INS_PRIO, 5'd0, 8'd7}, 1'b1,
        '{STAT_REFUSED, 1'b0, 5'd0, 1'b1, 5'd5, 6'd2}},
      '{'{FUNC_INS_PRIO, 5'd31, 8'd255}, 1'b0, FROM_MODEL},
      '{'{FUNC_INS_PRIO, 5'd1, 8'd0}, 1'b0, FROM_MODEL},
      '{'{FUNC_INS_PRIO, 5'd8, 8'd100}, 1'b0, FROM_MODEL},
      '{'{FUNC_INS_PRIO, 5'd2, 8'd128}, 1'b0, FROM_MODEL},
      '{'{FUNC_INS_TAIL, 5'd3, 8'd0}, 1'b0, FROM_MODEL},
      '{'{FUNC_INS_PRIO, 5'd4, 8'd1}, 1'b0, FROM_MODEL},
      '{'{FUNC_INS_PRIO, 5'd6, 8'd0}, 1'b0, FROM_MODEL},
      '{'{FUNC_REM_TASK, 5'd2, 8'd0}, 1'b0, FROM_MODEL},
      '{'{FUNC_REM_TASK, 5'd1, 8'd0}, 1'b0, FROM_MODEL},
      '{'{FUNC_REM_TASK, 5'd6, 8'd0}, 1'b0, FROM_MODEL},
      '{'{FUNC_REM_TASK, 5'd2, 8'd0}, 1'b0, FROM_MODEL},
      '{'{FUNC_REM_HEAD, 5'd31, 8'd255}, 1'b0, FROM_MODEL},
      '{'{FUNC_REM_HEAD, 5'd0, 8'd0}, 1'b0, FROM_MODEL},
      '{'{FUNC_REM_HEAD, 5'd0, 8'd0}, 1'b0, FROM_MODEL},
      '{'{FUNC_REM_HEAD, 5'd0, 8'd0}, 1'b0, FROM_MODEL},
      '{'{FUNC_REM_HEAD, 5'd0, 8'd0}, 1'b0, FROM_MODEL},
      '{'{FUNC_REM_HEAD, 5'd0, 8'd0}, 1'b0, FROM_MODEL},
      '{'{FUNC_REM_HEAD, 5'd0, 8'd0}, 1'b1,
        '{STAT_EMPTY, 1'b0, 5'd0, 1'b0, 5'd0, 6'd0}}
    };

    // Hold reset, then release it
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed table
    for (int n = 0; n < N_DIRECTED; n++)
      send(dir_table[n].item, dir_table[n].typed, dir_table[n].res);

    // Random fill and drain sequences, idling pattern changed per phase
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        hold_until_drained();
        mode = (n / PHASE_LEN) % 4;
        case (mode)
          0:       begin tx_pct = 0;  rx_pct = 0;  end
          1:       begin tx_pct = 55; rx_pct = 0;  end
          2:       begin tx_pct = 0;  rx_pct = 55; end
          default: begin tx_pct = 14; rx_pct = 14; end
        endcase
      end
      send(pick_item(), 1'b0, FROM_MODEL);
      // turn around at full and empty, lingering a little at each
      if (filling && q_len == MAX_TASKS && $urandom_range(0, 99) < 25) begin
        filling = 1'b0;
        n_fills++;
      end else if (!filling && q_len == 0 && $urandom_range(0, 99) < 25) begin
        filling = 1'b1;
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d items (%0d directed), checked %0d results, %0d errors.",
             n_items, N_DIRECTED, n_results, errors);
    $display("List filled to capacity %0d times, %0d inserts refused on a full list.",
             n_fills, n_full_refused);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl/core
rtl/core/trq_pkg.sv
rtl/core/trq_datapath.sv
rtl/core/trq_ctrl.sv
rtl/core/task_ready_queue.sv
dv/task_ready_queue_tb.sv
